@@ hw/rtl/slci_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment line clip package
// Shared types, widths, register codes and reset values for the segment
// versus clip line crossing unit.
// ----------------------------------------------------------------------------
package slci_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int COORD_W = 32;
   localparam int NORM_W  = 18;
   localparam int PROD_W  = NORM_W + COORD_W;
   localparam int DOT_W   = PROD_W + 1;
   localparam int DIFF_W  = COORD_W + 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_X     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_Y     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_OFFSET = 2'd2;

   localparam logic signed [NORM_W-1:0]  NORMAL_Y_RESET     = '0;
   localparam logic signed [COORD_W-1:0] PLANE_OFFSET_RESET = '0;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] cross_x;
      logic signed [COORD_W-1:0] cross_y;
   } rsp_type;

   // Segment and crossing decision carried alongside the divider and
   // interpolation stages.
   typedef struct packed {
      logic    hit;
      req_type seg;
   } side_type;

   // Width of an altitude: the shifted dot product or the offset, plus one
   // bit for the subtraction.
   function automatic int alt_width(int frac_bits);
      int sh_w;
      sh_w = DOT_W - frac_bits;
      return ((sh_w > COORD_W) ? sh_w : COORD_W) + 1;
   endfunction

endpackage

@@ hw/rtl/segment_line_clip_intersection_unit.sv @@
// Each accepted start passes through the altitude, divider and interpolation
// pipelines to its rsp_strobe cycle; the divider's one-bit-per-stage chain is
// the longest of the three.
// Throughput: one segment per cycle while busy is low; busy is set only by reset.
// Reset is synchronous: it clears all valid bits and loads the register
// defaults (normal 1.0, 0; offset 0); busy is high for one cycle after it.
// ----------------------------------------------------------------------------
// Segment line clip intersection unit
// Tests each segment against a configured clip line and returns the crossing
// point in fixed point, one result per segment.
// ----------------------------------------------------------------------------
module segment_line_clip_intersection_unit import slci_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LATENCY = FRAC_BITS + 8;
   localparam int MAG_W   = alt_width(FRAC_BITS);
   localparam logic signed [NORM_W-1:0] NORMAL_X_RESET = NORM_W'(64'sd1 <<< FRAC_BITS);

   logic                      busy_ff;
   logic                      accept;
   logic signed [NORM_W-1:0]  norm_x_ff, norm_y_ff;
   logic signed [COORD_W-1:0] offset_ff;

   logic                      alt_valid, div_valid;
   side_type                  alt_side, div_side;
   logic [MAG_W-1:0]          mag_s, mag_e;
   logic [FRAC_BITS-1:0]      frac;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_x_ff <= NORMAL_X_RESET;
         norm_y_ff <= NORMAL_Y_RESET;
         offset_ff <= PLANE_OFFSET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NORMAL_X:     norm_x_ff <= csr_wdata[NORM_W-1:0];
            CSR_NORMAL_Y:     norm_y_ff <= csr_wdata[NORM_W-1:0];
            CSR_PLANE_OFFSET: offset_ff <= csr_wdata[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   slci_alt #(.FRAC_BITS(FRAC_BITS)) u_alt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .norm_x    (norm_x_ff),
      .norm_y    (norm_y_ff),
      .offset    (offset_ff),
      .out_valid (alt_valid),
      .out_side  (alt_side),
      .out_mag_s (mag_s),
      .out_mag_e (mag_e)
   );

   slci_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (alt_valid),
      .in_side   (alt_side),
      .in_mag_s  (mag_s),
      .in_mag_e  (mag_e),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_frac  (frac)
   );

   slci_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_side    (div_side),
      .in_frac    (frac),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("accepted segment produced no result at the pipeline latency");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without a matching accepted segment");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.hit) |-> (rsp_data.cross_x == '0 && rsp_data.cross_y == '0))
      else $error("miss result carries a nonzero crossing point");

endmodule

@@ hw/rtl/slci_alt.sv @@
// ----------------------------------------------------------------------------
// Segment line clip altitude pipeline
// Four stages: normal products, dot sums, altitudes against the offset, and
// the crossing decision with altitude magnitudes.
// ----------------------------------------------------------------------------
module slci_alt import slci_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  req_type                   in_data,
   input  logic signed [NORM_W-1:0]  norm_x,
   input  logic signed [NORM_W-1:0]  norm_y,
   input  logic signed [COORD_W-1:0] offset,
   output logic                      out_valid,
   output side_type                  out_side,
   output logic [alt_width(FRAC_BITS)-1:0] out_mag_s,
   output logic [alt_width(FRAC_BITS)-1:0] out_mag_e
);

   localparam int SH_W  = DOT_W - FRAC_BITS;
   localparam int ALT_W = alt_width(FRAC_BITS);

   logic                     valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   req_type                  seg1_ff, seg2_ff, seg3_ff;
   side_type                 side4_ff;

   logic signed [PROD_W-1:0] psx_in, psy_in, pex_in, pey_in;
   logic signed [PROD_W-1:0] psx_ff, psy_ff, pex_ff, pey_ff;
   logic signed [DOT_W-1:0]  dot_s_in, dot_e_in, dot_s_ff, dot_e_ff;
   logic signed [SH_W-1:0]   sh_s, sh_e;
   logic signed [ALT_W-1:0]  alt_s_in, alt_e_in, alt_s_ff, alt_e_ff;
   logic [ALT_W-1:0]         mag_s_in, mag_e_in, mag_s_ff, mag_e_ff;
   logic                     hit_in;

   assign psx_in = norm_x * $signed(in_data.start_x);
   assign psy_in = norm_y * $signed(in_data.start_y);
   assign pex_in = norm_x * $signed(in_data.end_x);
   assign pey_in = norm_y * $signed(in_data.end_y);

   assign dot_s_in = DOT_W'(psx_ff) + DOT_W'(psy_ff);
   assign dot_e_in = DOT_W'(pex_ff) + DOT_W'(pey_ff);

   // Arithmetic shift rounds toward minus infinity; the kept bits hold the
   // whole shifted value.
   assign sh_s     = SH_W'(dot_s_ff >>> FRAC_BITS);
   assign sh_e     = SH_W'(dot_e_ff >>> FRAC_BITS);
   assign alt_s_in = ALT_W'(sh_s) - ALT_W'(offset);
   assign alt_e_in = ALT_W'(sh_e) - ALT_W'(offset);

   // A crossing needs both altitudes nonzero and of opposite sign.
   assign hit_in   = (alt_s_ff != '0) && (alt_e_ff != '0)
                     && (alt_s_ff[ALT_W-1] != alt_e_ff[ALT_W-1]);
   assign mag_s_in = alt_s_ff[ALT_W-1] ? ALT_W'(-alt_s_ff) : ALT_W'(alt_s_ff);
   assign mag_e_in = alt_e_ff[ALT_W-1] ? ALT_W'(-alt_e_ff) : ALT_W'(alt_e_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      seg1_ff      <= in_data;
      psx_ff       <= psx_in;
      psy_ff       <= psy_in;
      pex_ff       <= pex_in;
      pey_ff       <= pey_in;
      seg2_ff      <= seg1_ff;
      dot_s_ff     <= dot_s_in;
      dot_e_ff     <= dot_e_in;
      seg3_ff      <= seg2_ff;
      alt_s_ff     <= alt_s_in;
      alt_e_ff     <= alt_e_in;
      side4_ff.seg <= seg3_ff;
      side4_ff.hit <= hit_in;
      mag_s_ff     <= mag_s_in;
      mag_e_ff     <= mag_e_in;
   end

   assign out_valid = valid4_ff;
   assign out_side  = side4_ff;
   assign out_mag_s = mag_s_ff;
   assign out_mag_e = mag_e_ff;

endmodule

@@ hw/rtl/slci_div.sv @@
// ----------------------------------------------------------------------------
// Segment line clip fraction divider
// Pipelined restoring divider: t = floor(mag_s * 2^FRAC_BITS /
// (mag_s + mag_e)), one quotient bit per stage after a setup stage.
// ----------------------------------------------------------------------------
module slci_div import slci_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  side_type                        in_side,
   input  logic [alt_width(FRAC_BITS)-1:0] in_mag_s,
   input  logic [alt_width(FRAC_BITS)-1:0] in_mag_e,
   output logic                            out_valid,
   output side_type                        out_side,
   output logic [FRAC_BITS-1:0]            out_frac
);

   localparam int MAG_W = alt_width(FRAC_BITS);
   localparam int DEN_W = MAG_W + 1;

   logic                 valid_ff [0:FRAC_BITS];
   side_type             side_ff  [0:FRAC_BITS];
   logic [FRAC_BITS-1:0] quo_ff   [0:FRAC_BITS];
   logic [DEN_W-1:0]     rem_ff   [0:FRAC_BITS-1];
   logic [DEN_W-1:0]     den_ff   [0:FRAC_BITS-1];
   logic [DEN_W-1:0]     rem_in   [0:FRAC_BITS-1];
   logic                 ge_in    [0:FRAC_BITS-1];
   logic [DEN_W-1:0]     den_in;

   // The remainder starts below the divisor on a crossing, so every
   // quotient bit lands in FRAC_BITS bits.
   assign den_in = DEN_W'(in_mag_s) + DEN_W'(in_mag_e);

   always_comb begin
      logic [DEN_W:0] shl;
      for (int k = 0; k < FRAC_BITS; k++) begin
         shl       = {rem_ff[k], 1'b0};
         ge_in[k]  = shl >= {1'b0, den_ff[k]};
         rem_in[k] = ge_in[k] ? DEN_W'(shl - {1'b0, den_ff[k]}) : DEN_W'(shl);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= FRAC_BITS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 0; k < FRAC_BITS; k++) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      quo_ff[0]  <= '0;
      rem_ff[0]  <= DEN_W'(in_mag_s);
      den_ff[0]  <= den_in;
      for (int k = 0; k < FRAC_BITS; k++) begin
         side_ff[k+1] <= side_ff[k];
         quo_ff[k+1]  <= {quo_ff[k][FRAC_BITS-2:0], ge_in[k]};
      end
      for (int k = 0; k < FRAC_BITS - 1; k++) begin
         rem_ff[k+1] <= rem_in[k];
         den_ff[k+1] <= den_ff[k];
      end
   end

   assign out_valid = valid_ff[FRAC_BITS];
   assign out_side  = side_ff[FRAC_BITS];
   assign out_frac  = quo_ff[FRAC_BITS];

endmodule

@@ hw/rtl/slci_lerp.sv @@
// ----------------------------------------------------------------------------
// Segment line clip interpolation
// Three stages: axis differences, products with the fraction, and the
// shifted sum into the result register, zeroed on a miss.
// ----------------------------------------------------------------------------
module slci_lerp import slci_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  side_type             in_side,
   input  logic [FRAC_BITS-1:0] in_frac,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data
);

   localparam int MUL_W = DIFF_W + FRAC_BITS + 1;

   logic                     valid1_ff, valid2_ff, valid3_ff;
   side_type                 side1_ff, side2_ff;
   logic [FRAC_BITS-1:0]     frac1_ff;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic signed [MUL_W-1:0]  mx_in, my_in, mx_ff, my_ff;
   rsp_type                  rsp_in, rsp_ff;

   assign dx_in = DIFF_W'($signed(in_side.seg.end_x)) - DIFF_W'($signed(in_side.seg.start_x));
   assign dy_in = DIFF_W'($signed(in_side.seg.end_y)) - DIFF_W'($signed(in_side.seg.start_y));

   assign mx_in = dx_ff * $signed({1'b0, frac1_ff});
   assign my_in = dy_ff * $signed({1'b0, frac1_ff});

   // Only the low coordinate bits of the floored product matter, since the
   // crossing point lies between the two end points.
   always_comb begin
      rsp_in = '0;
      if (side2_ff.hit) begin
         rsp_in.hit     = 1'b1;
         rsp_in.cross_x = side2_ff.seg.start_x + mx_ff[FRAC_BITS +: COORD_W];
         rsp_in.cross_y = side2_ff.seg.start_y + my_ff[FRAC_BITS +: COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff <= in_side;
      frac1_ff <= in_frac;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      side2_ff <= side1_ff;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = valid3_ff;
   assign rsp_data   = rsp_ff;

endmodule
